>>> rtl/core/lpht_pkg.sv
// ============================================================================
// lpht_pkg - shared types and constants for the linear probe hash table
// Table geometry, command/status/mark codes, slot word layout and the
// command/status structs that join the controller and the datapath.
// ============================================================================
`default_nettype none

package lpht_pkg;

   // Table geometry; SLOTS must be a power of two (home slot = low hash bits)
   localparam int SLOTS      = 256;
   localparam int IDX_BITS   = $clog2(SLOTS);
   localparam int HASH_BITS  = 64;
   localparam int ITEM_BITS  = 64;
   localparam int DATA_BITS  = 64;
   localparam int COUNT_BITS = 9;
   localparam int CMD_BITS   = 2;
   localparam int STAT_BITS  = 2;
   localparam int MARK_BITS  = 2;

   localparam logic [COUNT_BITS-1:0] FILL_LIMIT_RESET = COUNT_BITS'(154);

   typedef logic [CMD_BITS-1:0]  cmd_type;
   typedef logic [STAT_BITS-1:0] status_type;
   typedef logic [MARK_BITS-1:0] mark_type;

   localparam cmd_type CMD_SET    = 2'd0;
   localparam cmd_type CMD_GET    = 2'd1;
   localparam cmd_type CMD_DELETE = 2'd2;

   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_MISS = 2'd1;
   localparam status_type STATUS_FULL = 2'd2;

   localparam mark_type MARK_EMPTY = 2'd0;
   localparam mark_type MARK_LIVE  = 2'd1;
   localparam mark_type MARK_TOMB  = 2'd2;

   typedef struct packed {
      mark_type               mark;
      logic [HASH_BITS-1:0]   hash;
      logic [ITEM_BITS-1:0]   item;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;        // capture request, point at home slot
      logic read;        // read slot at probe index
      logic advance;     // step probe index
      logic finish;      // apply table update, post result
      logic finish_nop;  // post miss for an unused command
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic nop;         // captured command is not set, get or delete
      logic hit_empty;   // slot just read is empty
      logic hit_match;   // slot just read is live with equal hash
      logic pass_end;    // last slot of a full pass
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/core/linear_probe_hash_table_top.sv
// ============================================================================
// linear_probe_hash_table_top - open-addressing hash table, linear probing
// Set, get and delete on a 256-slot table keyed by a 64-bit key hash.
// ============================================================================
//
// Usage:
//  - Request: drive req_command/req_key_hash/req_item_value and raise start;
//    the request is taken at the edge where start is high and busy is low.
//    Command set writes or inserts, get reads, delete leaves a tombstone.
//  - Result: rsp_status/rsp_item_out are valid for the single cycle that
//    rsp_strobe is high. There is no back pressure; the receiver must take
//    the result in that cycle.
//  - Timing: each probed slot takes a slot RAM read (ST_READ) and an
//    evaluate step (ST_EVAL); busy stays high until the probe ends. The
//    result shows in the cycle busy drops, so the next request can be
//    taken then. An unused command answers with a miss from ST_READ.
//  - Configuration: csr_wr_en/csr_wr_data write the fill limit; write it
//    only while busy is low.
//  - Reset: synchronous, clears all slot valid bits at once (every slot reads
//    empty), the live count, the result strobe, and loads fill limit 154.
//
`default_nettype none

module linear_probe_hash_table_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [lpht_pkg::CMD_BITS-1:0]     req_command,
   input  wire logic [lpht_pkg::HASH_BITS-1:0]    req_key_hash,
   input  wire logic [lpht_pkg::DATA_BITS-1:0]    req_item_value,
   // configuration
   input  wire logic                              csr_wr_en,
   input  wire logic [lpht_pkg::COUNT_BITS-1:0]   csr_wr_data,
   // result channel
   output logic                                   rsp_strobe,
   output logic      [lpht_pkg::STAT_BITS-1:0]    rsp_status,
   output logic      [lpht_pkg::DATA_BITS-1:0]    rsp_item_out
);

   // Sequencer commands and datapath probe status
   lpht_pkg::ctrl_cmd_type  ctrl;
   lpht_pkg::dp_status_type stat;

   // Probe sequencer: idle -> read slot -> evaluate, loop until done
   lpht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // Slot storage, probe index, counters and result register
   lpht_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_command    (req_command),
      .req_key_hash   (req_key_hash),
      .req_item_value (req_item_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_item_out   (rsp_item_out)
   );

endmodule

`default_nettype wire

>>> rtl/core/lpht_ram.sv
// ============================================================================
// lpht_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpht_datapath.sv
// ============================================================================
// lpht_datapath - probe datapath of the linear probe hash table
// Request capture, probe index, slot RAM with per-slot valid bits, live
// count, fill limit register and the result register.
// ============================================================================
`default_nettype none

module lpht_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lpht_pkg::ctrl_cmd_type                ctrl,
   output lpht_pkg::dp_status_type                    stat,
   input  wire logic [lpht_pkg::CMD_BITS-1:0]         req_command,
   input  wire logic [lpht_pkg::HASH_BITS-1:0]        req_key_hash,
   input  wire logic [lpht_pkg::DATA_BITS-1:0]        req_item_value,
   input  wire logic                                  csr_wr_en,
   input  wire logic [lpht_pkg::COUNT_BITS-1:0]       csr_wr_data,
   output logic                                       rsp_strobe,
   output logic      [lpht_pkg::STAT_BITS-1:0]        rsp_status,
   output logic      [lpht_pkg::DATA_BITS-1:0]        rsp_item_out
);

   lpht_pkg::cmd_type                    cmd_ff;
   logic [lpht_pkg::HASH_BITS-1:0]       hash_ff;
   logic [lpht_pkg::ITEM_BITS-1:0]       item_ff;
   logic [lpht_pkg::IDX_BITS-1:0]        idx_ff;
   logic [lpht_pkg::IDX_BITS-1:0]        idx_in;
   logic [lpht_pkg::IDX_BITS-1:0]        probe_cnt_ff;
   logic                                 valid_rd_ff;
   logic                                 valid_ff [lpht_pkg::SLOTS];
   logic [lpht_pkg::COUNT_BITS-1:0]      live_count_ff;
   logic [lpht_pkg::COUNT_BITS-1:0]      live_count_in;
   logic [lpht_pkg::COUNT_BITS-1:0]      fill_limit_ff;
   logic                                 rsp_valid_ff;
   lpht_pkg::status_type                 rsp_status_ff;
   lpht_pkg::status_type                 rsp_status_in;
   logic [lpht_pkg::DATA_BITS-1:0]       rsp_item_ff;
   logic [lpht_pkg::DATA_BITS-1:0]       rsp_item_in;

   lpht_pkg::slot_type                   slot_rd;
   lpht_pkg::slot_type                   slot_wr;
   logic                                 slot_wr_en;
   logic                                 slot_empty;
   logic                                 slot_match;

   lpht_ram #(
      .WIDTH (lpht_pkg::SLOT_BITS),
      .DEPTH (lpht_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (idx_ff),
      .wr_data (slot_wr),
      .rd_en   (ctrl.read),
      .rd_addr (idx_ff),
      .rd_data (slot_rd)
   );

   // A slot never written reads as empty
   assign slot_empty = !valid_rd_ff || (slot_rd.mark == lpht_pkg::MARK_EMPTY);
   assign slot_match = valid_rd_ff && (slot_rd.mark == lpht_pkg::MARK_LIVE) &&
                       (slot_rd.hash == hash_ff);

   assign stat.nop       = !((cmd_ff == lpht_pkg::CMD_SET) ||
                             (cmd_ff == lpht_pkg::CMD_GET) ||
                             (cmd_ff == lpht_pkg::CMD_DELETE));
   assign stat.hit_empty = slot_empty;
   assign stat.hit_match = slot_match;
   assign stat.pass_end  = (probe_cnt_ff == lpht_pkg::IDX_BITS'(lpht_pkg::SLOTS - 1));

   assign idx_in = (idx_ff == lpht_pkg::IDX_BITS'(lpht_pkg::SLOTS - 1)) ?
                   '0 : idx_ff + 1'b1;

   // Resolve the probe: table update, count update and result
   always_comb begin
      slot_wr_en    = 1'b0;
      slot_wr       = slot_rd;
      live_count_in = live_count_ff;
      rsp_status_in = lpht_pkg::STATUS_MISS;
      rsp_item_in   = '0;
      if (ctrl.finish) begin
         case (cmd_ff)
            lpht_pkg::CMD_SET: begin
               if (slot_match) begin
                  slot_wr_en    = 1'b1;
                  slot_wr.mark  = lpht_pkg::MARK_LIVE;
                  slot_wr.hash  = hash_ff;
                  slot_wr.item  = item_ff;
                  rsp_status_in = lpht_pkg::STATUS_OK;
               end else if (slot_empty && (live_count_ff < fill_limit_ff)) begin
                  slot_wr_en    = 1'b1;
                  slot_wr.mark  = lpht_pkg::MARK_LIVE;
                  slot_wr.hash  = hash_ff;
                  slot_wr.item  = item_ff;
                  live_count_in = live_count_ff + 1'b1;
                  rsp_status_in = lpht_pkg::STATUS_OK;
               end else begin
                  rsp_status_in = lpht_pkg::STATUS_FULL;
               end
            end
            lpht_pkg::CMD_GET: begin
               if (slot_match) begin
                  rsp_status_in = lpht_pkg::STATUS_OK;
                  rsp_item_in   = lpht_pkg::DATA_BITS'(slot_rd.item);
               end
            end
            lpht_pkg::CMD_DELETE: begin
               if (slot_match) begin
                  slot_wr_en    = 1'b1;
                  slot_wr.mark  = lpht_pkg::MARK_TOMB;
                  if (live_count_ff != '0) begin
                     live_count_in = live_count_ff - 1'b1;
                  end
                  rsp_status_in = lpht_pkg::STATUS_OK;
                  rsp_item_in   = lpht_pkg::DATA_BITS'(slot_rd.item);
               end
            end
            default: begin
               rsp_status_in = lpht_pkg::STATUS_MISS;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         live_count_ff <= '0;
         fill_limit_ff <= lpht_pkg::FILL_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (slot_wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         live_count_ff <= live_count_in;
         if (csr_wr_en) begin
            fill_limit_ff <= csr_wr_data;
         end
         rsp_valid_ff <= ctrl.finish || ctrl.finish_nop;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff       <= req_command;
         hash_ff      <= req_key_hash;
         item_ff      <= req_item_value[lpht_pkg::ITEM_BITS-1:0];
         idx_ff       <= req_key_hash[lpht_pkg::IDX_BITS-1:0];
         probe_cnt_ff <= '0;
      end else if (ctrl.advance) begin
         idx_ff       <= idx_in;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
      if (ctrl.read) begin
         valid_rd_ff <= valid_ff[idx_ff];
      end
      if (ctrl.finish || ctrl.finish_nop) begin
         rsp_status_ff <= rsp_status_in;
         rsp_item_ff   <= rsp_item_in;
      end
   end

   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_item_out = rsp_item_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpht_ctrl.sv
// ============================================================================
// lpht_ctrl - probe sequencer of the linear probe hash table
// Steps read/evaluate per probed slot until the probe terminates.
// ============================================================================
`default_nettype none

module lpht_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire lpht_pkg::dp_status_type stat,
   output lpht_pkg::ctrl_cmd_type       ctrl
);

   lpht_pkg::state_type state_ff;
   lpht_pkg::state_type state_in;
   logic                probe_done;

   assign probe_done = stat.hit_empty || stat.hit_match || stat.pass_end;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lpht_pkg::ST_READ;
            end
         end
         lpht_pkg::ST_READ: begin
            state_in = stat.nop ? lpht_pkg::ST_IDLE : lpht_pkg::ST_EVAL;
         end
         lpht_pkg::ST_EVAL: begin
            state_in = probe_done ? lpht_pkg::ST_IDLE : lpht_pkg::ST_READ;
         end
         default: begin
            state_in = lpht_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         lpht_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         lpht_pkg::ST_READ: begin
            ctrl.finish_nop = stat.nop;
            ctrl.read       = !stat.nop;
         end
         lpht_pkg::ST_EVAL: begin
            ctrl.finish  = probe_done;
            ctrl.advance = !probe_done;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpht_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lpht_checker.sv
// ============================================================================
// lpht_checker - port-level checks for the linear probe hash table
// Request/result ordering seen on the top level's ports.
// ============================================================================
`default_nettype none

module lpht_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_strobe,
   input wire logic [lpht_pkg::STAT_BITS-1:0]    rsp_status,
   input wire logic [lpht_pkg::DATA_BITS-1:0]    rsp_item_out
);

   // An accepted request holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // A result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request in flight");

   // A request ends in a result in the cycle busy drops
   a_drop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   // Only a hit carries an item
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != lpht_pkg::STATUS_OK) |-> rsp_item_out == '0)
      else $error("non-zero item on a miss or full result");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_item_out (rsp_item_out)
);

`default_nettype wire

>>> dv/linear_probe_hash_table_top_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_tb - self-checking bench for the probe table
// Drives set, get, delete and unused-command requests through the start/busy
// handshake and checks every strobed answer. Answers come from an in-bench
// mirror of the slot marks, hashes, items, live count and fill limit, or from
// a typed answer on a directed row. A short table of directed requests runs
// first; random phases follow, each under its own fill limit. Keys cluster on
// a few home slots so that probe chains, wraparound and tombstones come up
// often. One phase fills every slot so that probes run a whole pass.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Command code that the block does not implement
   localparam lpht_pkg::cmd_type CMD_UNUSED = 2'd3;

   localparam logic [lpht_pkg::HASH_BITS-1:0] KEY_ZERO  = 64'h0000_0000_0000_0000;
   localparam logic [lpht_pkg::HASH_BITS-1:0] KEY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [lpht_pkg::HASH_BITS-1:0] KEY_TOP   = 64'h8000_0000_0000_0000;
   localparam logic [lpht_pkg::HASH_BITS-1:0] KEY_WRAP  = 64'h0123_4567_89AB_CDFF;
   localparam logic [lpht_pkg::HASH_BITS-1:0] KEY_OTHER = 64'h0000_0000_0000_1234;
   localparam logic [lpht_pkg::DATA_BITS-1:0] ITEM_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [lpht_pkg::DATA_BITS-1:0] ITEM_5A   = 64'h5A5A_5A5A_5A5A_5A5A;
   localparam logic [lpht_pkg::DATA_BITS-1:0] ITEM_A5   = 64'hA5A5_A5A5_A5A5_A5A5;

   localparam int POOL_KEYS   = 40;
   localparam int PHASE_ITEMS = 235;

   typedef struct packed {
      lpht_pkg::status_type               status;
      logic [lpht_pkg::DATA_BITS-1:0]     item;
   } answer_type;

   typedef enum {PROBE_EMPTY, PROBE_MATCH, PROBE_WRAPPED} probe_outcome_type;

   typedef struct {
      bit                                 is_limit;
      logic [lpht_pkg::COUNT_BITS-1:0]    limit;
      lpht_pkg::cmd_type                  command;
      logic [lpht_pkg::HASH_BITS-1:0]     key;
      logic [lpht_pkg::DATA_BITS-1:0]     item;
      bit                                 typed;
      lpht_pkg::status_type               status;
      logic [lpht_pkg::DATA_BITS-1:0]     item_out;
   } directed_row_type;

   logic                               clock;
   logic                               reset          = 1'b1;
   logic                               start          = 1'b0;
   logic                               busy;
   logic [lpht_pkg::CMD_BITS-1:0]      req_command    = '0;
   logic [lpht_pkg::HASH_BITS-1:0]     req_key_hash   = '0;
   logic [lpht_pkg::DATA_BITS-1:0]     req_item_value = '0;
   logic                               csr_wr_en      = 1'b0;
   logic [lpht_pkg::COUNT_BITS-1:0]    csr_wr_data    = '0;
   logic                               rsp_strobe;
   logic [lpht_pkg::STAT_BITS-1:0]     rsp_status;
   logic [lpht_pkg::DATA_BITS-1:0]     rsp_item_out;

   // Hand-typed answer that travels with a directed request
   logic                               typed_check    = 1'b0;
   lpht_pkg::status_type               typed_status   = lpht_pkg::STATUS_OK;
   logic [lpht_pkg::DATA_BITS-1:0]     typed_item     = '0;

   linear_probe_hash_table_top uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_key_hash   (req_key_hash),
      .req_item_value (req_item_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_item_out   (rsp_item_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bound the run well beyond the slowest legal schedule
   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Mirror of the table
   // -------------------------------------------------------------------------
   lpht_pkg::mark_type                 mirror_mark [lpht_pkg::SLOTS];
   logic [lpht_pkg::HASH_BITS-1:0]     mirror_hash [lpht_pkg::SLOTS];
   logic [lpht_pkg::ITEM_BITS-1:0]     mirror_item [lpht_pkg::SLOTS];
   int                     live_total     = 0;
   int                     fill_limit_now = int'(lpht_pkg::FILL_LIMIT_RESET);

   answer_type             table_answers_due [$];
   int                     pending_n      = 0;   // queue depth as of last edge
   int                     mismatches     = 0;
   int                     full_passes    = 0;
   int                     limit_writes   = 0;
   int                     requests_by_cmd [4];
   int                     answers_by_status [4];

   initial begin
      foreach (mirror_mark[i]) mirror_mark[i] = lpht_pkg::MARK_EMPTY;
      foreach (requests_by_cmd[i]) requests_by_cmd[i] = 0;
      foreach (answers_by_status[i]) answers_by_status[i] = 0;
   end

   // Walk from the home slot; stop at an empty slot, a matching live slot or
   // after one whole lap of the table.
   function automatic probe_outcome_type probe_for(
         input logic [lpht_pkg::HASH_BITS-1:0] h, output int slot);
      int i;
      i = int'(h[lpht_pkg::IDX_BITS-1:0]);
      slot = 0;
      for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
         if (mirror_mark[i] == lpht_pkg::MARK_EMPTY) begin
            slot = i;
            return PROBE_EMPTY;
         end
         if (mirror_mark[i] == lpht_pkg::MARK_LIVE && mirror_hash[i] == h) begin
            slot = i;
            return PROBE_MATCH;
         end
         i = (i + 1) % lpht_pkg::SLOTS;
      end
      return PROBE_WRAPPED;
   endfunction

   task automatic table_apply(input lpht_pkg::cmd_type c,
                              input logic [lpht_pkg::HASH_BITS-1:0] h,
                              input logic [lpht_pkg::DATA_BITS-1:0] v,
                              output answer_type ans);
      int slot;
      probe_outcome_type hit;
      ans.status = lpht_pkg::STATUS_MISS;
      ans.item   = '0;
      if (c == lpht_pkg::CMD_SET || c == lpht_pkg::CMD_GET ||
          c == lpht_pkg::CMD_DELETE) begin
         hit = probe_for(h, slot);
         if (hit == PROBE_WRAPPED) full_passes++;
         case (c)
            lpht_pkg::CMD_SET: begin
               if (hit == PROBE_MATCH) begin
                  // overwrite: count unchanged, limit does not apply
                  mirror_item[slot] = v[lpht_pkg::ITEM_BITS-1:0];
                  ans.status = lpht_pkg::STATUS_OK;
               end else if (hit == PROBE_EMPTY && live_total < fill_limit_now) begin
                  mirror_mark[slot] = lpht_pkg::MARK_LIVE;
                  mirror_hash[slot] = h;
                  mirror_item[slot] = v[lpht_pkg::ITEM_BITS-1:0];
                  live_total++;
                  ans.status = lpht_pkg::STATUS_OK;
               end else begin
                  ans.status = lpht_pkg::STATUS_FULL;
               end
            end
            lpht_pkg::CMD_GET: begin
               if (hit == PROBE_MATCH) begin
                  ans.status = lpht_pkg::STATUS_OK;
                  ans.item   = lpht_pkg::DATA_BITS'(mirror_item[slot]);
               end
            end
            default: begin
               if (hit == PROBE_MATCH) begin
                  mirror_mark[slot] = lpht_pkg::MARK_TOMB;
                  if (live_total > 0) live_total--;
                  ans.status = lpht_pkg::STATUS_OK;
                  ans.item   = lpht_pkg::DATA_BITS'(mirror_item[slot]);
               end
            end
         endcase
      end
   endtask

   // -------------------------------------------------------------------------
   // Monitor: check strobed answers, track limit writes, predict accepted
   // requests. Everything is sampled at the rising edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_watch
      answer_type want;
      answer_type calc;
      if (!reset) begin
         if (rsp_strobe) begin
            answers_by_status[rsp_status]++;
            if (table_answers_due.size() == 0) begin
               $error("answer with no request waiting: status %0d item %h",
                      rsp_status, rsp_item_out);
               mismatches++;
            end else begin
               want = table_answers_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_item_out !== want.item) begin
                  $error("rsp_item_out: expected %h, got %h", want.item, rsp_item_out);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) fill_limit_now = int'(csr_wr_data);
         if (start && !busy) begin
            requests_by_cmd[req_command]++;
            table_apply(req_command, req_key_hash, req_item_value, calc);
            // directed rows with a typed answer take it in place of the mirror
            if (typed_check) begin
               calc.status = typed_status;
               calc.item   = typed_item;
            end
            table_answers_due.push_back(calc);
         end
      end
      pending_n <= table_answers_due.size();
   end

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------
   int burst_left = 0;

   // Present one request and hold it until the block takes it. Between bursts
   // drop start for a random gap and scramble the idle request fields.
   task automatic send_request(input lpht_pkg::cmd_type c,
                               input logic [lpht_pkg::HASH_BITS-1:0] k,
                               input logic [lpht_pkg::DATA_BITS-1:0] v,
                               input bit typed,
                               input lpht_pkg::status_type ts,
                               input logic [lpht_pkg::DATA_BITS-1:0] ti);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            start          <= 1'b0;
            req_command    <= lpht_pkg::CMD_BITS'($urandom);
            req_key_hash   <= {$urandom, $urandom};
            req_item_value <= {$urandom, $urandom};
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_command    <= c;
      req_key_hash   <= k;
      req_item_value <= v;
      typed_check    <= typed;
      typed_status   <= ts;
      typed_item     <= ti;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_checked(input lpht_pkg::cmd_type c,
                               input logic [lpht_pkg::HASH_BITS-1:0] k,
                               input logic [lpht_pkg::DATA_BITS-1:0] v);
      send_request(c, k, v, 1'b0, lpht_pkg::STATUS_OK, '0);
   endtask

   // Drain every outstanding request, then write the fill limit.
   task automatic write_fill_limit(input int value);
      start <= 1'b0;
      do @(posedge clock); while (pending_n != 0 || busy);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lpht_pkg::COUNT_BITS'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_writes++;
      burst_left = 0;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   directed_row_type directed_rows [$];

   task automatic add_request_row(input lpht_pkg::cmd_type c,
                                  input logic [lpht_pkg::HASH_BITS-1:0] k,
                                  input logic [lpht_pkg::DATA_BITS-1:0] v,
                                  input bit typed,
                                  input lpht_pkg::status_type ts,
                                  input logic [lpht_pkg::DATA_BITS-1:0] ti);
      directed_row_type row;
      row = '{1'b0, '0, c, k, v, typed, ts, ti};
      directed_rows.push_back(row);
   endtask

   task automatic add_limit_row(input int value);
      directed_row_type row;
      row = '{1'b1, lpht_pkg::COUNT_BITS'(value), lpht_pkg::CMD_GET, '0, '0, 1'b0,
              lpht_pkg::STATUS_OK, '0};
      directed_rows.push_back(row);
   endtask

   // Mostly land near a phase's cluster so that chains build up
   function automatic logic [lpht_pkg::HASH_BITS-1:0] make_key(
         input logic [lpht_pkg::IDX_BITS-1:0] base);
      logic [lpht_pkg::HASH_BITS-1:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0)
         k[lpht_pkg::IDX_BITS-1:0] = base +
                                     lpht_pkg::IDX_BITS'($urandom_range(0, 11));
      return k;
   endfunction

   function automatic logic [lpht_pkg::DATA_BITS-1:0] pick_item();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   logic [lpht_pkg::HASH_BITS-1:0] key_pool  [POOL_KEYS];
   logic [lpht_pkg::HASH_BITS-1:0] swept_key [lpht_pkg::SLOTS];
   int   limit_plan [6] = '{200, 1, 256, 93, 256, 154};
   localparam int SWEEP_PHASE = 4;

   initial begin
      logic [lpht_pkg::IDX_BITS-1:0]  base;
      logic [lpht_pkg::HASH_BITS-1:0] k;
      int                             r;
      lpht_pkg::cmd_type              c;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, from an empty table at the reset fill limit.
      // Lookups on the empty table, the unused command, extreme keys/items.
      add_request_row(lpht_pkg::CMD_GET,    KEY_ZERO, '0,   1, lpht_pkg::STATUS_MISS, '0);
      add_request_row(lpht_pkg::CMD_DELETE, KEY_ONES, '0,   1, lpht_pkg::STATUS_MISS, '0);
      add_request_row(CMD_UNUSED, KEY_ZERO, ITEM_ONES,      1, lpht_pkg::STATUS_MISS, '0);
      add_request_row(lpht_pkg::CMD_SET, KEY_ZERO, ITEM_ONES, 1, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_ZERO, '0, 1, lpht_pkg::STATUS_OK, ITEM_ONES);
      // Same home slot, different hash; then fill the last slot
      add_request_row(lpht_pkg::CMD_SET, KEY_TOP,  '0,        1, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_TOP,  ITEM_ONES, 1, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_SET, KEY_ONES, ITEM_5A,   1, lpht_pkg::STATUS_OK, '0);
      // Home on the last slot, chain wraps to the front
      add_request_row(lpht_pkg::CMD_SET, KEY_WRAP, ITEM_A5,   0, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_WRAP, '0,        0, lpht_pkg::STATUS_OK, '0);
      // Overwrite, then delete to leave a tombstone on the home slot
      add_request_row(lpht_pkg::CMD_SET, KEY_ZERO, 64'd1, 1, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_ZERO, '0,    1, lpht_pkg::STATUS_OK, 64'd1);
      add_request_row(lpht_pkg::CMD_DELETE, KEY_ZERO, '0, 1, lpht_pkg::STATUS_OK, 64'd1);
      add_request_row(lpht_pkg::CMD_GET, KEY_TOP,  '0,    0, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_ZERO, '0,    1, lpht_pkg::STATUS_MISS, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_WRAP, '0,    0, lpht_pkg::STATUS_OK, '0);
      add_request_row(CMD_UNUSED, KEY_TOP, ITEM_5A,       1, lpht_pkg::STATUS_MISS, '0);
      // Zero limit refuses new keys but still lets an overwrite through
      add_limit_row(0);
      add_request_row(lpht_pkg::CMD_SET, KEY_OTHER, ITEM_5A, 1, lpht_pkg::STATUS_FULL, '0);
      add_request_row(lpht_pkg::CMD_SET, KEY_TOP,   64'd7,   1, lpht_pkg::STATUS_OK,   '0);
      // Live count at the limit, then one below it; tombstone is not reused
      add_limit_row(3);
      add_request_row(lpht_pkg::CMD_SET, KEY_ZERO, ITEM_ONES, 1, lpht_pkg::STATUS_FULL, '0);
      add_request_row(lpht_pkg::CMD_DELETE, KEY_ONES, '0, 1, lpht_pkg::STATUS_OK, ITEM_5A);
      add_request_row(lpht_pkg::CMD_SET, KEY_ZERO, ITEM_ONES, 0, lpht_pkg::STATUS_OK, '0);
      add_request_row(lpht_pkg::CMD_GET, KEY_ZERO, '0, 1, lpht_pkg::STATUS_OK, ITEM_ONES);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_limit)
            write_fill_limit(int'(directed_rows[i].limit));
         else
            send_request(directed_rows[i].command, directed_rows[i].key,
                         directed_rows[i].item, directed_rows[i].typed,
                         directed_rows[i].status, directed_rows[i].item_out);
      end

      // Random phases, one fill limit each; keep part of the key pool so
      // later phases still find live keys.
      for (int p = 0; p < 6; p++) begin
         write_fill_limit(limit_plan[p]);
         base = lpht_pkg::IDX_BITS'($urandom);
         foreach (key_pool[i])
            if (p == 0 || $urandom_range(0, 1) == 0) key_pool[i] = make_key(base);

         if (p == SWEEP_PHASE) begin
            // Claim every empty slot so no empty one is left
            for (int s = 0; s < lpht_pkg::SLOTS; s++) begin
               k = {$urandom, $urandom};
               k[lpht_pkg::IDX_BITS-1:0] = lpht_pkg::IDX_BITS'(s);
               swept_key[s] = k;
               send_checked(lpht_pkg::CMD_SET, k, pick_item());
            end
            // Punch tombstones, then force whole-pass probes
            repeat (6) send_checked(lpht_pkg::CMD_DELETE,
                                    swept_key[$urandom_range(0, lpht_pkg::SLOTS-1)], '0);
            repeat (6) send_checked(lpht_pkg::CMD_SET, {$urandom, $urandom}, pick_item());
            repeat (4) send_checked(lpht_pkg::CMD_GET, {$urandom, $urandom}, '0);
            repeat (2) send_checked(lpht_pkg::CMD_DELETE, {$urandom, $urandom}, '0);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, POOL_KEYS-1)];
            if (r < 40) begin
               c = lpht_pkg::CMD_SET;
            end else if (r < 75) begin
               c = lpht_pkg::CMD_GET;
            end else if (r < 88) begin
               c = lpht_pkg::CMD_DELETE;
            end else if (r < 95) begin
               // fresh key: mostly misses and inserts
               c = lpht_pkg::cmd_type'($urandom_range(0, 2));
               k = make_key(base);
            end else begin
               c = CMD_UNUSED;
               k = {$urandom, $urandom};
            end
            send_checked(c, k, pick_item());
         end
      end

      // Drain, then leave room for a stray strobe to show up
      start <= 1'b0;
      do @(posedge clock); while (pending_n != 0 || busy);
      repeat (600) @(posedge clock);

      $display("Covered %0d set, %0d get, %0d delete, %0d unused; %0d limit writes.",
               requests_by_cmd[lpht_pkg::CMD_SET], requests_by_cmd[lpht_pkg::CMD_GET],
               requests_by_cmd[lpht_pkg::CMD_DELETE], requests_by_cmd[CMD_UNUSED],
               limit_writes);
      $display("Answers: %0d done, %0d not present, %0d full; %0d whole-lap probes.",
               answers_by_status[lpht_pkg::STATUS_OK],
               answers_by_status[lpht_pkg::STATUS_MISS],
               answers_by_status[lpht_pkg::STATUS_FULL], full_passes);
      if (mismatches == 0 && table_answers_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
